### hdl/sharp3_pkg.sv
// Shared types, constants and the per-channel sharpen function for the 3x3 RGB sharpen stream.
// Depends on nothing; the top level takes everything here by scoped names.
package sharp3_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int FW_W      = 12;
    localparam int FH_W      = 16;
    localparam int PIX_W     = 24;

    // Default frame geometry after reset.
    localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

    // Configuration register indexes.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Item opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // What the first stage does with its item.
    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_SHARP = 2'd1,
        MODE_PEND  = 2'd2
    } t_mode;

    // floor((11*c - 2*(u+d+l+r)) / 3), clamped to 0..255.
    // Values of 768 and above saturate, so the divide by three only sees ten bits
    // and a multiply by 683/2048 is exact there.
    function automatic logic [7:0] sharpen_chan(
        input logic [7:0] c,
        input logic [7:0] u,
        input logic [7:0] d,
        input logic [7:0] l,
        input logic [7:0] r
    );
        logic [9:0]  sum;
        logic [10:0] twice;
        logic [11:0] prod;
        logic [11:0] diff;
        logic [19:0] scaled;
        logic [7:0]  res;
        sum    = 10'(u) + 10'(d) + 10'(l) + 10'(r);
        twice  = {sum, 1'b0};
        prod   = 12'(c) * 12'd11;
        diff   = prod - 12'(twice);
        scaled = 20'(diff[9:0]) * 20'd683;
        if (prod <= 12'(twice)) begin
            res = 8'd0;
        end else if (diff >= 12'd768) begin
            res = 8'd255;
        end else begin
            res = scaled[18:11];
        end
        return res;
    endfunction

endpackage

### hdl/sharpen_3x3_rgb_stream.sv
// An accepted item is held in the line store read and first stage registers, then any result
// moves into the output register to be taken. Throughput: one item per cycle unless both
// stages hold items and the output is not taken; the output register and the first stage
// let a new item in while a finished result still waits to be taken.
// Reset clears the counters, the pending count, the valid flags and loads 640 x 480
// into the geometry registers. The line store is not cleared and needs no clearing pass.
// Top level of the 3x3 cross sharpen filter on an RGB raster stream.
// Depends on sharp3_pkg for constants, the mode type and the sharpen function.
module sharpen_3x3_rgb_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input items.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_pixel_red,
    input  logic [7:0]  i_pixel_green,
    input  logic [7:0]  i_pixel_blue,
    // Result items.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_frame_end
);

    localparam int CW = sharp3_pkg::COL_W;
    localparam int WW = sharp3_pkg::FW_W;
    localparam int HW = sharp3_pkg::FH_W;
    localparam int PW = sharp3_pkg::PIX_W;

    // Geometry registers and position counters.
    logic [WW-1:0] r_frame_width;
    logic [HW-1:0] r_frame_height;
    logic [CW-1:0] r_col_cnt;
    logic [HW-1:0] r_row_cnt;
    logic [WW-1:0] r_pend_cnt;

    // Line store: one bank per row parity, addressed by column.
    logic [PW-1:0] r_bank0 [sharp3_pkg::MAX_WIDTH];
    logic [PW-1:0] r_bank1 [sharp3_pkg::MAX_WIDTH];
    logic [PW-1:0] r_rda0, r_rda1, r_rdb0, r_rdb1;

    // First stage.
    logic              r_s1_valid;
    sharp3_pkg::t_mode r_s1_mode;
    logic              r_s1_end;
    logic              r_s1_cur;
    logic              r_s1_pbank;
    logic [PW-1:0]     r_s1_pix;
    logic [PW-1:0]     r_left0;
    logic [PW-1:0]     r_left1;

    // Output register.
    logic          r_o_valid;
    logic [PW-1:0] r_o_pix;
    logic          r_o_end;

    logic [WW-1:0]     w_eff_w;
    logic [HW-1:0]     w_eff_h;
    logic [CW-1:0]     w_col;
    logic [HW-1:0]     w_row;
    logic              w_last_col;
    logic              w_last_row;
    logic [WW-1:0]     w_pend_col;
    logic              w_is_pixel;
    logic              w_pend_hit;
    logic              w_accept;
    logic              w_pix_acc;
    logic              w_s1_move;
    logic              w_has_res;
    sharp3_pkg::t_mode w_mode;
    logic [CW-1:0]     w_addr_b;
    logic [PW-1:0]     w_in_pix;
    logic [PW-1:0]     w_center, w_up, w_right, w_left, w_pend_pix, w_sharp, w_res;

    // Effective frame size and clamped position of the incoming item.
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff_w = WW'(1);
        end else if (r_frame_width > WW'(sharp3_pkg::MAX_WIDTH)) begin
            w_eff_w = WW'(sharp3_pkg::MAX_WIDTH);
        end else begin
            w_eff_w = r_frame_width;
        end
        w_eff_h = (r_frame_height == '0) ? HW'(1) : r_frame_height;
        w_col   = (WW'(r_col_cnt) >= w_eff_w) ? CW'(w_eff_w - WW'(1)) : r_col_cnt;
        w_row   = (r_row_cnt >= w_eff_h) ? (w_eff_h - HW'(1)) : r_row_cnt;
        w_last_col = (WW'(w_col) + WW'(1)) >= w_eff_w;
        w_last_row = ({1'b0, w_row} + 17'd1) >= {1'b0, w_eff_h};
        w_pend_col = (r_pend_cnt >= w_eff_w) ? '0 : (w_eff_w - r_pend_cnt);
    end

    // Classify the item: does it flush a pending pixel, pass through, or get sharpened.
    always_comb begin
        w_is_pixel = (i_opcode == sharp3_pkg::OP_PIXEL);
        w_pend_hit = (r_pend_cnt != '0) && (!w_is_pixel || (w_row == '0));
        w_has_res  = w_pend_hit || (w_is_pixel && (w_row != '0));
        if (w_pend_hit) begin
            w_mode = sharp3_pkg::MODE_PEND;
        end else if ((w_row == HW'(1)) || (w_col == '0) || w_last_col) begin
            w_mode = sharp3_pkg::MODE_PASS;
        end else begin
            w_mode = sharp3_pkg::MODE_SHARP;
        end
        w_addr_b = w_pend_hit ? CW'(w_pend_col) : (w_col + CW'(1));
        w_in_pix = {i_pixel_red, i_pixel_green, i_pixel_blue};
    end

    // Handshake: the first stage moves on when the output register is free or drains.
    assign w_s1_move  = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || !r_o_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pix_acc  = w_accept && w_is_pixel;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sharp3_pkg::WIDTH_RESET;
            r_frame_height <= sharp3_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sharp3_pkg::CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data[WW-1:0];
            end else begin
                r_frame_height <= i_cfg_data;
            end
        end
    end

    // Position and pending counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt  <= '0;
            r_row_cnt  <= '0;
            r_pend_cnt <= '0;
        end else if (w_accept) begin
            // The final pixel of a frame reloads the pending count, even when it also flushes.
            if (w_is_pixel && w_last_col && w_last_row) begin
                r_pend_cnt <= w_eff_w;
            end else if (w_pend_hit) begin
                r_pend_cnt <= r_pend_cnt - WW'(1);
            end
            if (w_is_pixel) begin
                if (w_last_col) begin
                    r_col_cnt <= '0;
                    if (w_last_row) begin
                        r_row_cnt <= '0;
                    end else begin
                        r_row_cnt <= w_row + HW'(1);
                    end
                end else begin
                    r_col_cnt <= w_col + CW'(1);
                    r_row_cnt <= w_row;
                end
            end
        end
    end

    // Line store: port A reads the column of a pixel, port B the right neighbor or the
    // pending pixel. Reads see the data from before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (w_pix_acc) begin
            r_rda0 <= r_bank0[w_col];
            r_rda1 <= r_bank1[w_col];
            if (!w_row[0]) begin
                r_bank0[w_col] <= w_in_pix;
            end else begin
                r_bank1[w_col] <= w_in_pix;
            end
        end
        if (w_accept) begin
            r_rdb0 <= r_bank0[w_addr_b];
            r_rdb1 <= r_bank1[w_addr_b];
        end
    end

    // Select the neighbors from the two banks of the first stage.
    always_comb begin
        w_center   = r_s1_cur ? r_rda1 : r_rda0;
        w_up       = r_s1_cur ? r_rda0 : r_rda1;
        w_right    = r_s1_cur ? r_rdb1 : r_rdb0;
        w_left     = r_s1_cur ? r_left1 : r_left0;
        w_pend_pix = r_s1_pbank ? r_rdb1 : r_rdb0;
        w_sharp = {sharp3_pkg::sharpen_chan(w_center[23:16], w_up[23:16], r_s1_pix[23:16],
                                            w_left[23:16], w_right[23:16]),
                   sharp3_pkg::sharpen_chan(w_center[15:8], w_up[15:8], r_s1_pix[15:8],
                                            w_left[15:8], w_right[15:8]),
                   sharp3_pkg::sharpen_chan(w_center[7:0], w_up[7:0], r_s1_pix[7:0],
                                            w_left[7:0], w_right[7:0])};
        case (r_s1_mode)
            sharp3_pkg::MODE_SHARP: w_res = w_sharp;
            sharp3_pkg::MODE_PEND:  w_res = w_pend_pix;
            default:                w_res = w_center;
        endcase
    end

    // First stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= w_has_res;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // The left neighbor keeps both banks of the previous column: what the previous pixel
    // read there, or the previous pixel itself for the bank that it wrote.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_mode  <= w_mode;
            r_s1_end   <= w_pend_hit && (r_pend_cnt == WW'(1));
            r_s1_pbank <= w_eff_h[0] ^ 1'b1;
        end
        if (w_pix_acc) begin
            r_s1_cur <= ~w_row[0];
            r_s1_pix <= w_in_pix;
            r_left0  <= r_s1_cur ? r_s1_pix : r_rda0;
            r_left1  <= r_s1_cur ? r_rda1 : r_s1_pix;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_o_pix <= w_res;
            r_o_end <= r_s1_end;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_red   = r_o_pix[23:16];
    assign o_out_green = r_o_pix[15:8];
    assign o_out_blue  = r_o_pix[7:0];
    assign o_frame_end = r_o_end;

endmodule
